FILE: hw/rtl/sh4g_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sh4g_pkg;

    localparam int SIG_BITS   = 64;
    localparam int TALLY_W    = 18;
    localparam int GRAM_BYTES = 4;

    localparam logic signed [TALLY_W-1:0] TALLY_MAX = 18'sd131071;
    localparam logic signed [TALLY_W-1:0] TALLY_MIN = -18'sd131072;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] SEEN_FULL = 3'd4;

    // partial product steps of one 64-bit multiply
    localparam logic [1:0] PH_LO_LO = 2'd0;
    localparam logic [1:0] PH_LO_HI = 2'd1;
    localparam logic [1:0] PH_HI_LO = 2'd2;

    // mixer rounds
    localparam logic [1:0] RND_FIRST = 2'd0;
    localparam logic [1:0] RND_MID   = 2'd1;
    localparam logic [1:0] RND_LAST  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       mul;
        logic [1:0] phase;
        logic [1:0] round;
        logic       vote;
        logic       emit;
    } sh4g_cmd_t;

    typedef struct packed {
        logic empty;
        logic last;
        logic hash_now;
    } sh4g_status_t;

    function automatic logic [63:0] mix_const(input logic [1:0] round);
        logic [63:0] c;
        case (round)
            RND_FIRST: c = 64'h9E3779B97F4A7C15;
            RND_MID:   c = 64'hC2B2AE3D27D4EB4F;
            RND_LAST:  c = 64'h94D049BB133111EB;
            default:   c = 64'h0;
        endcase
        return c;
    endfunction

    function automatic logic [5:0] mix_shift(input logic [1:0] round);
        logic [5:0] s;
        case (round)
            RND_FIRST: s = 6'd33;
            RND_MID:   s = 6'd29;
            RND_LAST:  s = 6'd31;
            default:   s = 6'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sh4g_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module sh4g_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [7:0]                 data_byte,
    input  wire logic                       last,
    input  wire logic                       empty_req,
    input  wire sh4g_pkg::sh4g_cmd_t        cmd,
    output sh4g_pkg::sh4g_status_t          status,
    output logic [sh4g_pkg::SIG_BITS-1:0]   signature
);

    logic [31:0] window_reg;
    logic [2:0]  seen_reg;
    logic signed [sh4g_pkg::TALLY_W-1:0] tally_reg [sh4g_pkg::SIG_BITS];

    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] sig_reg;

    logic [31:0] window_next;
    logic [2:0]  seen_next;
    logic [31:0] padded;
    logic [63:0] mconst;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] prod;
    logic [63:0] h;
    logic [63:0] x_next;
    logic [sh4g_pkg::SIG_BITS-1:0] sig_now;

    assign window_next = {window_reg[23:0], data_byte};
    assign seen_next   = (seen_reg == sh4g_pkg::SEEN_FULL) ? sh4g_pkg::SEEN_FULL
                                                           : seen_reg + 3'd1;

    always_comb
    begin
        case (seen_next)
            3'd1:    padded = {window_next[7:0], {3{sh4g_pkg::PAD_BYTE}}};
            3'd2:    padded = {window_next[15:0], {2{sh4g_pkg::PAD_BYTE}}};
            3'd3:    padded = {window_next[23:0], sh4g_pkg::PAD_BYTE};
            default: padded = window_next;
        endcase
    end

    assign status.empty    = empty_req;
    assign status.last     = last;
    assign status.hash_now = (seen_next == sh4g_pkg::SEEN_FULL) || last;

    // one 32x32 multiplier, three partial products per 64-bit multiply
    assign mconst = sh4g_pkg::mix_const(cmd.round);

    always_comb
    begin
        case (cmd.phase)
            sh4g_pkg::PH_LO_LO:
            begin
                ma = x_reg[31:0];
                mb = mconst[31:0];
            end
            sh4g_pkg::PH_LO_HI:
            begin
                ma = x_reg[31:0];
                mb = mconst[63:32];
            end
            sh4g_pkg::PH_HI_LO:
            begin
                ma = x_reg[63:32];
                mb = mconst[31:0];
            end
            default:
            begin
                ma = 32'd0;
                mb = 32'd0;
            end
        endcase
    end

    assign prod   = {32'd0, ma} * {32'd0, mb};
    assign h      = {acc_reg[63:32] + prod[31:0], acc_reg[31:0]};
    assign x_next = h ^ (h >> sh4g_pkg::mix_shift(cmd.round));

    always_comb
    begin
        for (int b = 0; b < sh4g_pkg::SIG_BITS; b++)
        begin
            sig_now[b] = !tally_reg[b][sh4g_pkg::TALLY_W-1] && (tally_reg[b] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            for (int b = 0; b < sh4g_pkg::SIG_BITS; b++)
            begin
                tally_reg[b] <= '0;
            end
        end
        else if (cmd.clear || cmd.emit)
        begin
            window_reg <= '0;
            seen_reg   <= '0;
            for (int b = 0; b < sh4g_pkg::SIG_BITS; b++)
            begin
                tally_reg[b] <= '0;
            end
        end
        else if (cmd.load)
        begin
            window_reg <= window_next;
            seen_reg   <= seen_next;
        end
        else if (cmd.vote)
        begin
            for (int b = 0; b < sh4g_pkg::SIG_BITS; b++)
            begin
                if (x_reg[b])
                begin
                    if (tally_reg[b] != sh4g_pkg::TALLY_MAX)
                    begin
                        tally_reg[b] <= tally_reg[b] + 18'sd1;
                    end
                end
                else if (tally_reg[b] != sh4g_pkg::TALLY_MIN)
                begin
                    tally_reg[b] <= tally_reg[b] - 18'sd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= {32'd0, padded};
        end
        else if (cmd.mul)
        begin
            case (cmd.phase)
                sh4g_pkg::PH_LO_LO: acc_reg <= prod;
                sh4g_pkg::PH_LO_HI: acc_reg <= h;
                sh4g_pkg::PH_HI_LO: x_reg   <= x_next;
                default:            acc_reg <= acc_reg;
            endcase
        end
        if (cmd.emit)
        begin
            sig_reg <= sig_now;
        end
    end

    assign signature = sig_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/sh4g_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sh4g_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    input  wire sh4g_pkg::sh4g_status_t status,
    output sh4g_pkg::sh4g_cmd_t         cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_VOTE,
        ST_FINISH
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] round_reg;
    logic [1:0] round_next;
    logic       last_reg;
    logic       last_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       slot_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        round_next     = round_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.phase      = phase_reg;
        cmd.round      = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (status.empty)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.load  = 1'b1;
                        last_next = status.last;
                        if (status.hash_now)
                        begin
                            phase_next = sh4g_pkg::PH_LO_LO;
                            round_next = sh4g_pkg::RND_FIRST;
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (phase_reg == sh4g_pkg::PH_HI_LO)
                begin
                    phase_next = sh4g_pkg::PH_LO_LO;
                    if (round_reg == sh4g_pkg::RND_LAST)
                    begin
                        state_next = ST_VOTE;
                    end
                    else
                    begin
                        round_next = round_reg + 2'd1;
                    end
                end
                else
                begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            ST_VOTE:
            begin
                cmd.vote   = 1'b1;
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= sh4g_pkg::PH_LO_LO;
            round_reg     <= sh4g_pkg::RND_FIRST;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result emitted over a pending beat");

    a_mul_ends_in_vote: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && phase_reg == sh4g_pkg::PH_HI_LO
         && round_reg == sh4g_pkg::RND_LAST) |=> (state_reg == ST_VOTE))
        else $error("mixer did not hand over to vote");

    a_empty_goes_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.empty) |=> (state_reg == ST_FINISH))
        else $error("empty text did not produce a result");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (phase_reg != 2'd3 && round_reg != 2'd3))
        else $error("multiplier sequencing out of range");

endmodule

`default_nettype wire

FILE: hw/rtl/simhash_4gram_signature.sv
`timescale 1ns / 1ps
`default_nettype none

// 64-bit simhash over the byte 4-grams of a text streamed one byte per beat, tlast on
// the final byte, tuser set for an empty text (signature 0, partial text dropped).
// One signature beat comes out per text. A byte that completes a 4-gram, or the
// last byte of a short text, is accepted, then passes the mixer (one shared 32x32
// multiplier forms each of the three 64-bit products from three partial products)
// and then updates all 64 tallies at once. The first three bytes of a longer text
// are only shifted into the window. The end of a text passes a finish state that
// forms the signature; the next text may start while that beat waits on m_tready.

module simhash_4gram_signature (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,   // last
    input  wire logic        s_tuser,   // empty_req
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // signature
);

    sh4g_pkg::sh4g_cmd_t    cmd;
    sh4g_pkg::sh4g_status_t status;

    sh4g_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .cmd       (cmd)
    );

    sh4g_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (s_tdata),
        .last      (s_tlast),
        .empty_req (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .signature (m_tdata)
    );

endmodule

`default_nettype wire
